>>> rtl/key_edge_and_accelerating_repeat_macros.svh
// Assertion macros used by the top RTL file of the key repeat block.
`ifndef KEY_EDGE_AND_ACCELERATING_REPEAT_MACROS_SVH
`define KEY_EDGE_AND_ACCELERATING_REPEAT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KAR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("key repeat assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("key repeat assertion failed");

`endif

>>> rtl/kar_pkg.sv
`default_nettype none

package kar_pkg;

    // Field and register widths.
    localparam int KEY_BITS  = 8;
    localparam int TIMER_W   = 16;
    localparam int IV_W      = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(TIMER_W);

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_THREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_FOUR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_ONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TWO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_THR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_FOU = 3'd7;

    // Register reset values.
    localparam logic [TIMER_W-1:0] RST_REPEAT_START = 16'd200;
    localparam logic [TIMER_W-1:0] RST_STAGE_TWO    = 16'd500;
    localparam logic [TIMER_W-1:0] RST_STAGE_THREE  = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_STAGE_FOUR   = 16'd1500;
    localparam logic [IV_W-1:0]    RST_INTERVAL_ONE = 8'd20;
    localparam logic [IV_W-1:0]    RST_INTERVAL_TWO = 8'd5;
    localparam logic [IV_W-1:0]    RST_INTERVAL_THR = 8'd2;
    localparam logic [IV_W-1:0]    RST_INTERVAL_FOU = 8'd1;

    // Repeat configuration as seen by every lane.
    typedef struct packed {
        logic [TIMER_W-1:0] repeat_start;
        logic [TIMER_W-1:0] stage_two;
        logic [TIMER_W-1:0] stage_three;
        logic [TIMER_W-1:0] stage_four;
        logic [IV_W-1:0]    interval_one;
        logic [IV_W-1:0]    interval_two;
        logic [IV_W-1:0]    interval_three;
        logic [IV_W-1:0]    interval_four;
    } kar_cfg_t;

    // Sequencer commands broadcast to the lanes.
    typedef struct packed {
        logic load;   // a tick is accepted: update the hold timer
        logic setup;  // pick the interval and the dividend
        logic step;   // one remainder step
    } kar_lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/kar_lane.sv
`default_nettype none

module kar_lane
    import kar_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire kar_lane_ctrl_t ctrl,
    input  wire kar_cfg_t       cfg,
    input  wire logic           key_down,
    input  wire logic           key_press,
    output logic                pulse
);

    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [TIMER_W-1:0] timer_base;
    logic [TIMER_W-1:0] dvd_reg;
    logic [IV_W-1:0]    iv_reg;
    logic [IV_W-1:0]    rem_reg;
    logic               elig_reg;
    logic [IV_W-1:0]    stage_iv;
    logic [IV_W-1:0]    iv_eff;
    logic [IV_W:0]      trial;
    logic [IV_W:0]      diff;
    logic [IV_W-1:0]    rem_step;

    // Hold timer update: a press restarts it, a released key clears it, a held key counts up and saturates.
    always_comb begin
        timer_base = key_press ? '0 : timer_reg;
        if (!key_down) begin
            timer_next = '0;
        end else if (timer_base == TIMER_MAX) begin
            timer_next = timer_base;
        end else begin
            timer_next = timer_base + 1'b1;
        end
    end

    // Stage selection, latest threshold first; a zero interval acts as one.
    always_comb begin
        if (timer_reg >= cfg.stage_four) begin
            stage_iv = cfg.interval_four;
        end else if (timer_reg >= cfg.stage_three) begin
            stage_iv = cfg.interval_three;
        end else if (timer_reg >= cfg.stage_two) begin
            stage_iv = cfg.interval_two;
        end else begin
            stage_iv = cfg.interval_one;
        end
        iv_eff = (stage_iv == '0) ? IV_W'(1) : stage_iv;
    end

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial    = {rem_reg, dvd_reg[TIMER_W-1]};
        diff     = trial - {1'b0, iv_reg};
        rem_step = diff[IV_W] ? trial[IV_W-1:0] : diff[IV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            elig_reg  <= 1'b0;
        end else begin
            if (ctrl.load) begin
                timer_reg <= timer_next;
            end
            if (ctrl.setup) begin
                elig_reg <= key_down && (timer_reg >= cfg.repeat_start);
            end
        end
    end

    // Remainder datapath.
    always_ff @(posedge aclk) begin
        if (ctrl.setup) begin
            dvd_reg <= timer_reg - cfg.repeat_start;
            iv_reg  <= iv_eff;
            rem_reg <= '0;
        end else if (ctrl.step) begin
            dvd_reg <= {dvd_reg[TIMER_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign pulse = elig_reg && (rem_reg == '0);

endmodule

`default_nettype wire

>>> rtl/kar_merge.sv
`default_nettype none

module kar_merge
    import kar_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire logic [KEY_BITS-1:0] press_bits,
    input  wire logic [KEY_BITS-1:0] release_bits,
    input  wire logic [LANES-1:0]    lane_pulse,
    output logic                     can_push,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [KEY_BITS-1:0]      m_pressed_keys,
    output logic [KEY_BITS-1:0]      m_released_keys,
    output logic [KEY_BITS-1:0]      m_repeat_pulses
);

    logic                out_valid_reg;
    logic [KEY_BITS-1:0] pressed_reg;
    logic [KEY_BITS-1:0] released_reg;
    logic [KEY_BITS-1:0] pulses_reg;

    // The output register takes a new result once its current one is gone.
    assign can_push = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Gather the press and release bits and the lane pulses into one result word.
    always_ff @(posedge aclk) begin
        if (push) begin
            pressed_reg  <= press_bits;
            released_reg <= release_bits;
            pulses_reg   <= KEY_BITS'(lane_pulse);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pressed_keys  = pressed_reg;
    assign m_released_keys = released_reg;
    assign m_repeat_pulses = pulses_reg;

endmodule

`default_nettype wire

>>> rtl/key_edge_and_accelerating_repeat.sv
// Key edge detector with accelerating auto-repeat.
// Input channel (s_valid/s_ready, s_key_levels): one transfer per millisecond
// tick with the levels of up to eight keys. Output channel (m_valid/m_ready):
// one transfer per tick with press edges, release edges and repeat pulses.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) holding
// the repeat thresholds and intervals; write it only while the block is idle.
// Each key has a lane with its own hold timer and a bit-serial remainder unit.
// A tick passes from its input transfer through the timer update, the stage
// selection and 16 one-bit remainder steps before its result is shown on
// m_valid. A new tick is taken only once the current one has reached the
// output register; s_ready stays low while the remainder loop runs.
// While the output register still holds an untaken result, the finished tick
// waits in the lanes and s_ready stays low until the output register frees.
// Reset clears all hold timers and the previous key levels and loads the
// default thresholds (200, 500, 1000, 1500) and intervals (20, 5, 2, 1).
`default_nettype none

`include "key_edge_and_accelerating_repeat_macros.svh"

module key_edge_and_accelerating_repeat
    import kar_pkg::*;
#(
    parameter int NUM_KEYS = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [KEY_BITS-1:0]  s_key_levels,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KEY_BITS-1:0]       m_pressed_keys,
    output logic [KEY_BITS-1:0]       m_released_keys,
    output logic [KEY_BITS-1:0]       m_repeat_pulses
);

    // Only the first NUM_KEYS keys, at most the field width, are visible; further keys never go down.
    localparam int Lanes = (NUM_KEYS < KEY_BITS) ? NUM_KEYS : KEY_BITS;
    localparam logic [KEY_BITS-1:0] KeyMask = KEY_BITS'((2 ** Lanes) - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [KEY_BITS-1:0]  last_reg;
    logic [KEY_BITS-1:0]  press_reg;
    logic [KEY_BITS-1:0]  release_reg;
    logic [KEY_BITS-1:0]  cur;
    logic [KEY_BITS-1:0]  press_now;
    kar_cfg_t             cfg_reg;
    kar_lane_ctrl_t       lane_ctrl;
    logic [Lanes-1:0]     lane_pulse;
    logic                 accept;
    logic                 can_push;
    logic                 push;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_start   <= RST_REPEAT_START;
            cfg_reg.stage_two      <= RST_STAGE_TWO;
            cfg_reg.stage_three    <= RST_STAGE_THREE;
            cfg_reg.stage_four     <= RST_STAGE_FOUR;
            cfg_reg.interval_one   <= RST_INTERVAL_ONE;
            cfg_reg.interval_two   <= RST_INTERVAL_TWO;
            cfg_reg.interval_three <= RST_INTERVAL_THR;
            cfg_reg.interval_four  <= RST_INTERVAL_FOU;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_REPEAT_START: cfg_reg.repeat_start   <= cfg_wdata;
                REG_STAGE_TWO:    cfg_reg.stage_two      <= cfg_wdata;
                REG_STAGE_THREE:  cfg_reg.stage_three    <= cfg_wdata;
                REG_STAGE_FOUR:   cfg_reg.stage_four     <= cfg_wdata;
                REG_INTERVAL_ONE: cfg_reg.interval_one   <= cfg_wdata[IV_W-1:0];
                REG_INTERVAL_TWO: cfg_reg.interval_two   <= cfg_wdata[IV_W-1:0];
                REG_INTERVAL_THR: cfg_reg.interval_three <= cfg_wdata[IV_W-1:0];
                REG_INTERVAL_FOU: cfg_reg.interval_four  <= cfg_wdata[IV_W-1:0];
                default: ;
            endcase
        end
    end

    // Edge detection against the previous tick.
    assign cur       = s_key_levels & KeyMask;
    assign press_now = cur & ~last_reg;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign push      = (state_reg == ST_DONE) && can_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else if (accept) begin
            last_reg <= cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            press_reg   <= press_now;
            release_reg <= ~cur & last_reg & KeyMask;
        end
    end

    // Sequencer shared by all lanes.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) begin
                state_next = ST_SETUP;
            end
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:   if (count_reg == '1) begin
                state_next = ST_DONE;
            end
            ST_DONE:  if (can_push) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                count_reg <= '0;
            end
        end
    end

    assign lane_ctrl.load  = accept;
    assign lane_ctrl.setup = (state_reg == ST_SETUP);
    assign lane_ctrl.step  = (state_reg == ST_DIV);

    // One lane per visible key.
    for (genvar i = 0; i < Lanes; i++) begin : g_lane
        kar_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .cfg       (cfg_reg),
            .key_down  (lane_ctrl.load ? cur[i] : last_reg[i]),
            .key_press (press_now[i]),
            .pulse     (lane_pulse[i])
        );
    end

    kar_merge #(
        .LANES (Lanes)
    ) u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .press_bits      (press_reg),
        .release_bits    (release_reg),
        .lane_pulse      (lane_pulse),
        .can_push        (can_push),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pressed_keys  (m_pressed_keys),
        .m_released_keys (m_released_keys),
        .m_repeat_pulses (m_repeat_pulses)
    );

    // A tick transfer always starts the lane sequence.
    `KAR_ASSERT_NEXT(a_accept_setup, aclk, aresetn, accept, state_reg == ST_SETUP)
    // A finished tick that cannot leave keeps waiting.
    `KAR_ASSERT_NEXT(a_done_hold, aclk, aresetn, (state_reg == ST_DONE) && !can_push,
        state_reg == ST_DONE)
    // A key never goes both down and up in the same tick.
    `KAR_ASSERT_SAME(a_edge_excl, aclk, aresetn, m_valid,
        (m_pressed_keys & m_released_keys) == '0)
    // Only a key that is down now can emit a repeat pulse.
    `KAR_ASSERT_SAME(a_pulse_down, aclk, aresetn, push,
        (KEY_BITS'(lane_pulse) & ~last_reg) == '0)

endmodule

`default_nettype wire
